// File: src/bmp_pkg.sv
`timescale 1ns / 1ps
package bmp_pkg;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_WIDTH_DEF = 16384;
    localparam int HEIGHT_LIMIT = 16384;

    typedef enum logic [3:0] {
        PH_PAL    = 4'd0,
        PH_PIX    = 4'd1,
        PH_PAD    = 4'd2,
        PH_CMD    = 4'd3,
        PH_RUN    = 4'd4,
        PH_ESC    = 4'd5,
        PH_DX     = 4'd6,
        PH_DY     = 4'd7,
        PH_ABS    = 4'd8,
        PH_ABSPAD = 4'd9,
        PH_STOP   = 4'd10
    } t_phase;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [1:0] DEPTH_4  = 2'd0;
    localparam logic [1:0] DEPTH_8  = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;
    localparam logic [1:0] DEPTH_32 = 2'd3;

    localparam logic [1:0] CFG_DEPTH  = 2'd0;
    localparam logic [1:0] CFG_RLE    = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    // parser result handed to the output stage; colours come as palette
    // indexes or as a direct colour, resolved after the palette read
    typedef struct packed {
        logic        valid;
        logic [13:0] row;
        logic [13:0] col;
        logic [14:0] count;
        logic        use_pal_a;
        logic        use_pal_b;
        logic [7:0]  idx_a;
        logic [7:0]  idx_b;
        logic [23:0] direct;
        logic [1:0]  status;
    } t_res;

    // palette write request
    typedef struct packed {
        logic        we;
        logic [7:0]  addr;
        logic [23:0] data;
    } t_pwr;
endpackage

// File: src/bmp_pixel_array_decoder_top.sv
`timescale 1ns / 1ps
// channel  dir  fields (lsb first)
// s_axis   in   tdata: data_byte[7:0]; tuser: image_start
// m_axis   out  tdata: out_row, out_column, run_count, colour_a, colour_b, status; tlast
// cfg      in   i_cfg_we, i_cfg_index[1:0], i_cfg_data[14:0]
// One byte per cycle. A byte is parsed in the cycle it is taken; the palette
// read is registered with the result in stage 1, and the output register takes it from there.
// Two-deep path: the input is held off only when the output register is full
// and not being taken. Reset is synchronous, active low; palette is not cleared.
module bmp_pixel_array_decoder_top import bmp_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // image_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_row[13:0], out_column[27:14], run_count[42:28], colour_a[66:43],
    // colour_b[90:67], status[92:91], zero fill to 96
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [14:0]  i_cfg_data
);
    logic [1:0]  r_depth;
    logic        r_rle;
    logic [14:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_8; r_rle <= 1'b0; r_width <= 15'd1; r_height <= 15'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEPTH:  r_depth  <= i_cfg_data[1:0];
                CFG_RLE:    r_rle    <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic step;
    t_res res;
    t_pwr pwr;
    t_res r_s1;
    logic r_s1_v;
    logic [23:0] pal_a, pal_b;
    logic r_out_v;
    logic adv;

    // stage 1 advances when the output register is free or being drained
    assign adv = !r_out_v || m_axis_tready;
    assign s_axis_tready = adv;
    assign step = s_axis_tvalid && s_axis_tready;

    bmp_parser #(.MAX_WIDTH(MAX_WIDTH)) u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_byte(s_axis_tdata), .i_start(s_axis_tuser),
        .i_depth(r_depth), .i_rle(r_rle), .i_width(r_width), .i_height(r_height),
        .o_res(res), .o_pwr(pwr)
    );

    t_pwr pwr_g;
    always_comb begin
        pwr_g = pwr;
        pwr_g.we = pwr.we && step;
    end

    bmp_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_pal (
        .i_clk(i_clk), .i_wr(pwr_g), .i_en(adv),
        .i_addr_a(res.idx_a), .i_addr_b(res.idx_b),
        .o_data_a(pal_a), .o_data_b(pal_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_v <= 1'b0;
        else if (adv) r_s1_v <= step && res.valid;
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_s1 <= res;
    end

    // output word
    logic [95:0] r_data;
    logic        r_last;
    logic [23:0] ca, cb;
    assign ca = r_s1.use_pal_a ? pal_a : r_s1.direct;
    assign cb = r_s1.use_pal_b ? pal_b : r_s1.direct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (adv) r_out_v <= r_s1_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last <= (r_s1.status != ST_RUN);
            if (r_s1.status == ST_ERR || (r_s1.status == ST_DONE && r_s1.count == 15'd0)) begin
                r_data <= {3'd0, r_s1.status, 91'd0};
            end else begin
                r_data <= {3'd0, r_s1.status, cb, ca, r_s1.count, r_s1.col, r_s1.row};
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = r_data;
    assign m_axis_tlast = r_last;

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[92:91] != ST_RUN)))
        else $error("tlast disagrees with status");
    a_no_err3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[92:91] != 2'd3))
        else $error("bad status code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !m_axis_tready) |=> $stable(r_data))
        else $error("output word changed while stalled");
endmodule

// File: src/bmp_palette.sv
`timescale 1ns / 1ps
module bmp_palette import bmp_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  t_pwr        i_wr,
    input  logic        i_en,
    input  logic [7:0]  i_addr_a,
    input  logic [7:0]  i_addr_b,
    output logic [23:0] o_data_a,
    output logic [23:0] o_data_b
);
    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    logic [23:0] r_mem [PALETTE_DEPTH];
    logic [23:0] r_a;
    logic [23:0] r_b;
    logic        r_ok_a;
    logic        r_ok_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.we && (32'(i_wr.addr) < PALETTE_DEPTH)) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= r_mem[i_addr_a[AW-1:0]];
            r_b    <= r_mem[i_addr_b[AW-1:0]];
            r_ok_a <= 32'(i_addr_a) < PALETTE_DEPTH;
            r_ok_b <= 32'(i_addr_b) < PALETTE_DEPTH;
        end
    end

    assign o_data_a = r_ok_a ? r_a : 24'd0;
    assign o_data_b = r_ok_b ? r_b : 24'd0;
endmodule

// File: src/bmp_parser.sv
`timescale 1ns / 1ps
module bmp_parser import bmp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic [1:0]  i_depth,
    input  logic        i_rle,
    input  logic [14:0] i_width,
    input  logic [14:0] i_height,
    output t_res        o_res,
    output t_pwr        o_pwr
);
    t_phase      r_phase, n_phase;
    logic [16:0] r_col, n_col;
    logic [14:0] r_row, n_row;
    logic [9:0]  r_cnt, n_cnt;
    logic [7:0]  r_abs, n_abs;
    logic [23:0] r_acc, n_acc;

    t_phase      ph;
    logic [16:0] col;
    logic [14:0] row;
    logic [9:0]  cnt;
    logic [7:0]  absr;
    logic [23:0] acc;
    logic [16:0] w;
    logic [14:0] h;
    logic        four;
    logic [16:0] col_plus_b;
    logic [16:0] rowbytes;
    logic [1:0]  pad;
    logic [1:0]  ncnt;

    always_comb begin
        w = {2'b0, i_width};
        if (w == 17'd0) w = 17'd1;
        if (w > 17'(MAX_WIDTH)) w = 17'(MAX_WIDTH);
        h = i_height;
        if (h == 15'd0) h = 15'd1;
        if (h > 15'(HEIGHT_LIMIT)) h = 15'(HEIGHT_LIMIT);
    end

    always_comb begin
        ph = r_phase; col = r_col; row = r_row; cnt = r_cnt; absr = r_abs; acc = r_acc;
        if (i_start) begin
            col = '0; row = '0; cnt = '0; absr = '0; acc = '0;
            ph = (i_depth >= DEPTH_24) ? PH_PIX : PH_PAL;
        end
        four = (i_depth == DEPTH_4);
        col_plus_b = col + 17'(i_byte);
        n_phase = ph; n_col = col; n_row = row; n_cnt = cnt; n_abs = absr; n_acc = acc;
        o_pwr = '0;
        o_res = '0;
        o_res.row = 14'(h - 15'd1 - row);
        o_res.col = col[13:0];
        ncnt = 2'd0;
        rowbytes = '0;
        pad = '0;

        unique case (ph)
            PH_PAL: begin
                case (cnt[1:0])
                    2'd0: n_acc = {16'd0, i_byte};
                    2'd1: n_acc = {8'd0, i_byte, acc[7:0]};
                    2'd2: begin
                        n_acc = {i_byte, acc[15:0]};
                        o_pwr.we = 1'b1;
                        o_pwr.addr = cnt[9:2];
                        o_pwr.data = {i_byte, acc[15:0]};
                    end
                    default: ;
                endcase
                if ((11'(cnt) + 11'd1) >= (four ? 11'd64 : 11'd1024)) begin
                    n_cnt = '0;
                    n_acc = '0;
                    n_phase = (i_rle && i_depth < DEPTH_24) ? PH_CMD : PH_PIX;
                end else begin
                    n_cnt = cnt + 10'd1;
                end
            end
            PH_PIX: begin
                if (row >= h || col >= w) begin
                    o_res.valid = 1'b1;
                    o_res.status = ST_ERR;
                    o_res.row = '0; o_res.col = '0;
                    n_phase = PH_STOP;
                end else begin
                    case (i_depth)
                        DEPTH_4: begin
                            ncnt = ((w - col) >= 17'd2) ? 2'd2 : 2'd1;
                            o_res.use_pal_a = 1'b1; o_res.use_pal_b = 1'b1;
                            o_res.idx_a = {4'd0, i_byte[7:4]};
                            o_res.idx_b = (ncnt == 2'd2) ? {4'd0, i_byte[3:0]}
                                                         : {4'd0, i_byte[7:4]};
                        end
                        DEPTH_8: begin
                            ncnt = 2'd1;
                            o_res.use_pal_a = 1'b1; o_res.use_pal_b = 1'b1;
                            o_res.idx_a = i_byte; o_res.idx_b = i_byte;
                        end
                        default: begin
                            if (cnt == 10'd0) n_acc = {16'd0, i_byte};
                            else if (cnt == 10'd1) n_acc = {8'd0, i_byte, acc[7:0]};
                            else if (cnt == 10'd2) n_acc = {i_byte, acc[15:0]};
                            if (cnt >= ((i_depth == DEPTH_24) ? 10'd2 : 10'd3)) ncnt = 2'd1;
                            o_res.direct = n_acc;
                        end
                    endcase
                    if (ncnt == 2'd0) begin
                        n_cnt = cnt + 10'd1;
                    end else begin
                        n_cnt = '0;
                        o_res.valid = 1'b1;
                        o_res.count = 15'(ncnt);
                        n_col = col + 17'(ncnt);
                        if (n_col >= w) begin
                            case (i_depth)
                                DEPTH_4:  rowbytes = (w + 17'd1) >> 1;
                                DEPTH_8:  rowbytes = w;
                                DEPTH_24: rowbytes = w + (w << 1);
                                default:  rowbytes = w << 2;
                            endcase
                            pad = 2'd0 - rowbytes[1:0];
                            n_col = '0;
                            n_row = row + 15'd1;
                            if (n_row >= h) begin
                                o_res.status = ST_DONE;
                                n_phase = PH_STOP;
                            end else if (pad != 2'd0) begin
                                n_cnt = 10'(pad);
                                n_phase = PH_PAD;
                            end
                        end
                    end
                end
            end
            PH_PAD: begin
                if (cnt > 10'd1) n_cnt = cnt - 10'd1;
                else begin n_cnt = '0; n_phase = PH_PIX; end
            end
            PH_CMD: begin
                if (i_byte == 8'd0) n_phase = PH_ESC;
                else if (row >= h || col_plus_b > w) begin
                    o_res = '0; o_res.valid = 1'b1; o_res.status = ST_ERR;
                    n_phase = PH_STOP;
                end else begin
                    n_abs = i_byte;
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                o_res.valid = 1'b1;
                o_res.count = 15'(absr);
                o_res.use_pal_a = 1'b1; o_res.use_pal_b = 1'b1;
                if (four) begin
                    o_res.idx_a = {4'd0, i_byte[7:4]};
                    o_res.idx_b = (absr >= 8'd2) ? {4'd0, i_byte[3:0]} : {4'd0, i_byte[7:4]};
                end else begin
                    o_res.idx_a = i_byte; o_res.idx_b = i_byte;
                end
                n_col = col + 17'(absr);
                n_abs = '0;
                n_phase = PH_CMD;
            end
            PH_ESC: begin
                if (i_byte == 8'd0) begin
                    if (row >= h) begin
                        o_res = '0; o_res.valid = 1'b1; o_res.status = ST_ERR;
                        n_phase = PH_STOP;
                    end else begin
                        if (col < w) begin
                            o_res.valid = 1'b1;
                            o_res.count = 15'(w - col);
                        end
                        n_col = '0;
                        n_row = row + 15'd1;
                        n_phase = PH_CMD;
                    end
                end else if (i_byte == 8'd1) begin
                    o_res = '0; o_res.valid = 1'b1; o_res.status = ST_DONE;
                    n_phase = PH_STOP;
                end else if (i_byte == 8'd2) begin
                    if (!four) begin
                        o_res = '0; o_res.valid = 1'b1; o_res.status = ST_ERR;
                        n_phase = PH_STOP;
                    end else n_phase = PH_DX;
                end else if (row >= h || col_plus_b > w) begin
                    o_res = '0; o_res.valid = 1'b1; o_res.status = ST_ERR;
                    n_phase = PH_STOP;
                end else begin
                    n_abs = i_byte;
                    // odd count of data bytes gets one pad byte
                    n_cnt = four ? {9'd0, (i_byte[1:0] == 2'd1 || i_byte[1:0] == 2'd2)}
                                 : {9'd0, i_byte[0]};
                    n_phase = PH_ABS;
                end
            end
            PH_DX: begin
                n_abs = i_byte;
                n_phase = PH_DY;
            end
            PH_DY: begin
                n_abs = '0;
                if (i_byte != 8'd0) begin
                    o_res = '0; o_res.valid = 1'b1; o_res.status = ST_ERR;
                    n_phase = PH_STOP;
                end else begin
                    n_phase = PH_CMD;
                    if (absr != 8'd0) begin
                        if (row >= h || (col + 17'(absr)) > w) begin
                            o_res = '0; o_res.valid = 1'b1; o_res.status = ST_ERR;
                            n_phase = PH_STOP;
                        end else begin
                            o_res.valid = 1'b1;
                            o_res.count = 15'(absr);
                            n_col = col + 17'(absr);
                        end
                    end
                end
            end
            PH_ABS: begin
                o_res.use_pal_a = 1'b1; o_res.use_pal_b = 1'b1;
                if (four) begin
                    ncnt = (absr >= 8'd2) ? 2'd2 : 2'd1;
                    o_res.idx_a = {4'd0, i_byte[7:4]};
                    o_res.idx_b = (ncnt == 2'd2) ? {4'd0, i_byte[3:0]} : {4'd0, i_byte[7:4]};
                end else begin
                    ncnt = 2'd1;
                    o_res.idx_a = i_byte; o_res.idx_b = i_byte;
                end
                if (absr == 8'd0) ncnt = 2'd0;
                if (ncnt == 2'd0) n_phase = PH_CMD;
                else begin
                    o_res.valid = 1'b1;
                    o_res.count = 15'(ncnt);
                    n_col = col + 17'(ncnt);
                    n_abs = absr - 8'(ncnt);
                    if (n_abs == 8'd0) begin
                        n_phase = (cnt != 10'd0) ? PH_ABSPAD : PH_CMD;
                        n_cnt = '0;
                    end
                end
            end
            PH_ABSPAD: n_phase = PH_CMD;
            default: n_phase = PH_STOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PAL;
            r_col <= '0; r_row <= '0; r_cnt <= '0; r_abs <= '0; r_acc <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_col <= n_col; r_row <= n_row; r_cnt <= n_cnt; r_abs <= n_abs; r_acc <= n_acc;
        end
    end
endmodule
